// ===== hw/rtl/ecc33_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecc33_pkg
// Shared constants, Q.16 coefficients and the log2 mantissa table for the
// ECC-33 path loss pipeline.
// ----------------------------------------------------------------------------
package ecc33_pkg;

	localparam int LOG_TAB_BITS      = 8;
	localparam int LOG_TABLE_ENTRIES = 1 << LOG_TAB_BITS;

	localparam int LOG_IN_W  = 20;
	localparam int LOG_OUT_W = 20;

	typedef logic [16:0] log_tab_t [0:LOG_TABLE_ENTRIES];

	// register indexes
	localparam logic [1:0] REG_CARRIER  = 2'd0;
	localparam logic [1:0] REG_TX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RX_HEIGHT = 2'd2;
	localparam logic [1:0] REG_SUBURBAN = 2'd3;

	localparam logic [30:0] LOG10_OF_2_Q32 = 31'd1292913987;
	// n / 100 == (n * MAGIC_DIV100) >> 37 for any 32-bit n
	localparam logic [30:0] MAGIC_DIV100   = 31'd1374389535;

	localparam logic signed [31:0] C_AFS     = 32'sd6055526;
	localparam logic signed [31:0] C_ABM     = 32'sd1337590;
	localparam logic signed [31:0] C_ABM_D   = 32'sd644219;
	localparam logic signed [31:0] C_ABM_F   = 32'sd517079;
	localparam logic signed [31:0] C_ABM_F2  = 32'sd626524;
	localparam logic signed [31:0] C_GB_OFS  = 32'sd914751;
	localparam logic signed [31:0] C_GB_D    = 32'sd380109;
	localparam logic signed [20:0] C_LOG_KM  = 21'sd196608;
	localparam logic signed [20:0] C_LOG_2000 = 21'sd216336;
	localparam logic signed [20:0] C_LOG_100 = 21'sd131072;
	localparam logic [15:0]        C_GRU_H   = 16'd49742;
	localparam logic signed [31:0] C_GRU_OFS = 32'sd122028;
	localparam logic signed [31:0] C_GRS_OFS = 32'sd2789868;
	localparam logic signed [31:0] C_GRS_F   = 32'sd897843;
	localparam logic signed [31:0] C_GRS_H   = 32'sd38339;

	// fraction of log2(x) over [1,2), one entry per mantissa step, last = 1.0
	function automatic log_tab_t build_log_tab();
		log_tab_t    tab;
		logic [63:0] x;
		logic [16:0] y;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LOG_TAB_BITS));
			y = '0;
			for (int b = 15; b >= 0; b--) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					x    = x >> 1;
					y[b] = 1'b1;
				end
			end
			tab[i] = (i == LOG_TABLE_ENTRIES) ? 17'd65536 : y;
		end
		return tab;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage
`default_nettype wire

// ===== hw/rtl/ecc33_log10.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecc33_log10
// Four-stage log10 in Q.16: leading-one normalize, table lookup,
// linear interpolation, scale by log10(2).
// ----------------------------------------------------------------------------
module ecc33_log10 (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [ecc33_pkg::LOG_IN_W-1:0]   v,
	output logic      [ecc33_pkg::LOG_OUT_W-1:0]  log10_q16
);
	import ecc33_pkg::*;

	localparam int TAIL_W = 32 - LOG_TAB_BITS;

	logic [LOG_IN_W-1:0]      vv;
	logic [4:0]               msb;
	logic [LOG_IN_W-1:0]      rem;
	logic [LOG_IN_W+31:0]     fw;

	logic [4:0]               msb_s1;
	logic [LOG_TAB_BITS-1:0]  idx_s1;
	logic [TAIL_W-1:0]        tail_s1;

	logic [16:0]              lo;
	logic [16:0]              hi;
	logic [4:0]               msb_s2;
	logic [16:0]              lo_s2;
	logic [16:0]              diff_s2;
	logic [TAIL_W-1:0]        tail_s2;

	logic [16+TAIL_W:0]       interp_p;
	logic [20:0]              log2_s3;

	logic [51:0]              prod_s4;
	logic [52:0]              rnd;

	always_comb begin
		vv  = (v == '0) ? LOG_IN_W'(1) : v;
		msb = '0;
		for (int i = 0; i < LOG_IN_W; i++) begin
			if (vv[i]) begin
				msb = 5'(i);
			end
		end
		rem = vv & ~(LOG_IN_W'(1) << msb);
		fw  = {rem, 32'd0} >> msb;
	end

	always_comb begin
		lo = LOG_TAB[idx_s1];
		hi = LOG_TAB[{1'b0, idx_s1} + (LOG_TAB_BITS+1)'(1)];
	end

	assign interp_p = diff_s2 * tail_s2;
	assign rnd       = 53'(prod_s4) + (53'd1 << 31);
	assign log10_q16 = rnd[32 +: LOG_OUT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			msb_s1  <= msb;
			idx_s1  <= fw[31 -: LOG_TAB_BITS];
			tail_s1 <= fw[TAIL_W-1:0];

			msb_s2  <= msb_s1;
			lo_s2   <= lo;
			diff_s2 <= (hi > lo) ? (hi - lo) : 17'd0;
			tail_s2 <= tail_s1;

			log2_s3 <= (21'(msb_s2) << 16) + 21'(lo_s2) + 21'(interp_p >> TAIL_W);

			prod_s4 <= 52'(log2_s3) * 52'(LOG10_OF_2_Q32);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ecc33_path_loss.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecc33_path_loss
// ECC-33 path loss and received power, one result beat per input beat.
// ----------------------------------------------------------------------------
// Input beat (in_valid/in_ready): distance_m and tx_power_q8. Output beat
// (out_valid/out_ready): rx_power_q8, path_loss_q8 and clamp_flag, in Q16.8.
// Settings are written through cfg_we/cfg_index/cfg_data: 0 carrier MHz,
// 1 tx height dm, 2 rx height cm, 3 suburban mode; write only while idle.
// An accepted input beat reaches out_valid through twelve pipeline stages
// (four log10 units working side by side, then the coefficient multiplies).
// One beat per cycle is sustained while the pipeline is not frozen.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the default settings
// (2000 MHz, 50 m, 3 m, urban). No warm-up pass is needed.
// ----------------------------------------------------------------------------
module ecc33_path_loss (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [19:0]        distance_m,
	input  wire logic signed [15:0] tx_power_q8,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [23:0]      rx_power_q8,
	output logic signed [23:0]      path_loss_q8,
	output logic                    clamp_flag
);
	import ecc33_pkg::*;

	function automatic logic signed [31:0] rnd16(input logic signed [47:0] p);
		logic signed [47:0] q;
		q = p + 48'sd32768;
		return $signed(q[47:16]);
	endfunction

	logic [15:0] carrier_q;
	logic [15:0] tx_height_q;
	logic [15:0] rx_height_q;
	logic        suburban_q;

	logic        adv;
	logic [11:0] vld;

	logic [19:0] dist_c;
	logic [15:0] hr_c;
	logic [19:0] log_d, log_f, log_h, log_r;

	// side lanes carried past the log10 units
	logic signed [15:0] tx_s1, tx_s2, tx_s3, tx_s4, tx_s5, tx_s6, tx_s7, tx_s8;
	logic signed [15:0] tx_s9, tx_s10, tx_s11;
	logic flag_s1, flag_s2, flag_s3, flag_s4, flag_s5, flag_s6, flag_s7, flag_s8;
	logic flag_s9, flag_s10, flag_s11;
	logic sub_s1, sub_s2, sub_s3, sub_s4, sub_s5, sub_s6, sub_s7, sub_s8;
	logic [31:0]        gru_mul_s1;
	logic [61:0]        gru_mag_s2;
	logic signed [31:0] gru_s3, gru_s4, gru_s5, gru_s6, gru_s7, gru_s8;

	logic signed [20:0] ld_s5, lf_s5, lh_s5, lr_s5;
	logic signed [20:0] lh_s6, lh_s7, lh_s8, lh_s9;

	logic signed [47:0] p_abmd_s6, p_abmf_s6, p_ff_s6, p_gbd_s6, p_grsf_s6;
	logic signed [31:0] afs_s6, afs_s7, afs_s8, lrh_s6, lrh_s7;

	logic signed [31:0] abmp_s7, abmp_s8, lf2_s7, term_s7, gs_s7;
	logic signed [47:0] p_a2_s8, p_tt_s8, p_gs_s8;

	logic signed [31:0] rest_s9, rest_s10, tt_s9, loss_s11;
	logic signed [47:0] p_gb_s10;

	logic signed [33:0] rx_w, rx_r, loss_r;
	logic               sat_rx_hi, sat_rx_lo, sat_l_hi, sat_l_lo;

	assign adv       = !vld[11] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld[11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q   <= 16'd2000;
			tx_height_q <= 16'd500;
			rx_height_q <= 16'd300;
			suburban_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CARRIER:   carrier_q   <= cfg_data;
				REG_TX_HEIGHT: tx_height_q <= cfg_data;
				REG_RX_HEIGHT: rx_height_q <= cfg_data;
				REG_SUBURBAN:  suburban_q  <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[10:0], in_valid};
		end
	end

	assign dist_c = (distance_m == '0) ? 20'd1 : distance_m;
	assign hr_c   = (rx_height_q == '0) ? 16'd1 : rx_height_q;

	ecc33_log10 u_log_d (.clk(clk), .en(adv), .v(dist_c),              .log10_q16(log_d));
	ecc33_log10 u_log_f (.clk(clk), .en(adv), .v(20'(carrier_q)),      .log10_q16(log_f));
	ecc33_log10 u_log_h (.clk(clk), .en(adv), .v(20'(tx_height_q)),    .log10_q16(log_h));
	ecc33_log10 u_log_r (.clk(clk), .en(adv), .v(20'(rx_height_q)),    .log10_q16(log_r));

	// output rounding to Q.8 and saturation
	always_comb begin
		rx_w      = (34'(tx_s11) <<< 8) - 34'(loss_s11);
		rx_r      = (rx_w + 34'sd128) >>> 8;
		loss_r    = (34'(loss_s11) + 34'sd128) >>> 8;
		sat_rx_hi = rx_r > 34'sd8388607;
		sat_rx_lo = rx_r < -34'sd8388608;
		sat_l_hi  = loss_r > 34'sd8388607;
		sat_l_lo  = loss_r < -34'sd8388608;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stages 1-4: alongside the log10 units
			tx_s1      <= tx_power_q8;
			flag_s1    <= (distance_m == '0);
			sub_s1     <= suburban_q;
			gru_mul_s1 <= 32'(hr_c) * 32'(C_GRU_H) + 32'd50;

			tx_s2      <= tx_s1;
			flag_s2    <= flag_s1;
			sub_s2     <= sub_s1;
			gru_mag_s2 <= 62'(gru_mul_s1) * 62'(MAGIC_DIV100);

			tx_s3      <= tx_s2;
			flag_s3    <= flag_s2;
			sub_s3     <= sub_s2;
			gru_s3     <= $signed(32'(gru_mag_s2 >> 37)) - C_GRU_OFS;

			tx_s4      <= tx_s3;
			flag_s4    <= flag_s3;
			sub_s4     <= sub_s3;
			gru_s4     <= gru_s3;

			// stage 5: remove unit offsets
			ld_s5   <= $signed({1'b0, log_d}) - C_LOG_KM;
			lf_s5   <= $signed({1'b0, log_f}) - C_LOG_KM;
			lh_s5   <= $signed({1'b0, log_h}) - C_LOG_2000;
			lr_s5   <= $signed({1'b0, log_r}) - C_LOG_100;
			tx_s5   <= tx_s4;
			flag_s5 <= flag_s4;
			sub_s5  <= sub_s4;
			gru_s5  <= gru_s4;

			// stage 6: first coefficient products
			p_abmd_s6 <= 48'(ld_s5) * 48'(C_ABM_D);
			p_abmf_s6 <= 48'(lf_s5) * 48'(C_ABM_F);
			p_ff_s6   <= 48'(lf_s5) * 48'(lf_s5);
			p_gbd_s6  <= 48'(ld_s5) * 48'(C_GB_D);
			p_grsf_s6 <= 48'(lf_s5) * 48'(C_GRS_F);
			afs_s6    <= C_AFS + 32'(ld_s5) * 32'sd20 + 32'(lf_s5) * 32'sd20;
			lrh_s6    <= 32'(lr_s5) - C_GRS_H;
			lh_s6     <= lh_s5;
			tx_s6     <= tx_s5;
			flag_s6   <= flag_s5;
			sub_s6    <= sub_s5;
			gru_s6    <= gru_s5;

			// stage 7
			abmp_s7 <= C_ABM + rnd16(p_abmd_s6) + rnd16(p_abmf_s6);
			lf2_s7  <= rnd16(p_ff_s6);
			term_s7 <= C_GB_OFS + rnd16(p_gbd_s6);
			gs_s7   <= C_GRS_OFS + rnd16(p_grsf_s6);
			afs_s7  <= afs_s6;
			lrh_s7  <= lrh_s6;
			lh_s7   <= lh_s6;
			tx_s7   <= tx_s6;
			flag_s7 <= flag_s6;
			sub_s7  <= sub_s6;
			gru_s7  <= gru_s6;

			// stage 8: second products
			p_a2_s8 <= 48'(lf2_s7) * 48'(C_ABM_F2);
			p_tt_s8 <= 48'(term_s7) * 48'(term_s7);
			p_gs_s8 <= 48'(gs_s7) * 48'(lrh_s7);
			afs_s8  <= afs_s7;
			abmp_s8 <= abmp_s7;
			lh_s8   <= lh_s7;
			tx_s8   <= tx_s7;
			flag_s8 <= flag_s7;
			sub_s8  <= sub_s7;
			gru_s8  <= gru_s7;

			// stage 9: everything but the tx height gain
			rest_s9 <= afs_s8 + abmp_s8 + rnd16(p_a2_s8)
				- (sub_s8 ? rnd16(p_gs_s8) : gru_s8);
			tt_s9   <= rnd16(p_tt_s8);
			lh_s9   <= lh_s8;
			tx_s9   <= tx_s8;
			flag_s9 <= flag_s8;

			// stage 10: tx height gain product
			p_gb_s10 <= 48'(lh_s9) * 48'(tt_s9);
			rest_s10 <= rest_s9;
			tx_s10   <= tx_s9;
			flag_s10 <= flag_s9;

			// stage 11
			loss_s11 <= rest_s10 - rnd16(p_gb_s10);
			tx_s11   <= tx_s10;
			flag_s11 <= flag_s10;

			// stage 12: output register
			rx_power_q8  <= sat_rx_hi ? 24'sd8388607 :
				sat_rx_lo ? -24'sd8388608 : rx_r[23:0];
			path_loss_q8 <= sat_l_hi ? 24'sd8388607 :
				sat_l_lo ? -24'sd8388608 : loss_r[23:0];
			clamp_flag   <= flag_s11 || sat_rx_hi || sat_rx_lo || sat_l_hi || sat_l_lo;
		end
	end

endmodule
`default_nettype wire
